FILE: rtl/pise_pkg.sv
// Shared types, constants and helpers for the particle integrator step core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pise_pkg;

    typedef enum logic [1:0] {
        MODE_EULER    = 2'd0,
        MODE_MIDPOINT = 2'd1,
        MODE_RK4      = 2'd2,
        MODE_EULER_B  = 2'd3
    } mode_t;

    typedef enum logic {
        REG_MODE      = 1'b0,
        REG_TIME_STEP = 1'b1
    } reg_index_t;

    localparam logic [23:0] TIME_STEP_RESET = 24'd134218;

    // quotient bits resolved per divider stage, and stage count
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = 10;
    // input capture + divider stages + saturation stage
    localparam int DIV_LAT            = DIV_STAGES + 2;
    // multiply, round, second multiply, final sum
    localparam int TOTAL_LAT          = DIV_LAT + 4;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] sat35(input logic signed [34:0] x);
        logic signed [31:0] y;
        begin
            if (x > 35'sh0_7FFF_FFFF)
                y = S32_MAX;
            else if (x < -35'sh0_8000_0000)
                y = S32_MIN;
            else
                y = x[31:0];
            return y;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pise_div.sv
// Pipelined restoring divider: a = sat32((f * 256) / m), truncated toward zero.
// Four quotient bits per stage. Depends on pise_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pise_div (
    input  wire logic               clk,
    input  wire logic signed [31:0] f,
    input  wire logic        [15:0] m,
    output logic signed [31:0]      a
);

    logic [39:0] num_reg [0:pise_pkg::DIV_STAGES];
    logic [15:0] rem_reg [0:pise_pkg::DIV_STAGES];
    logic [15:0] m_reg   [0:pise_pkg::DIV_STAGES];
    logic        neg_reg [0:pise_pkg::DIV_STAGES];
    logic        zero_reg[0:pise_pkg::DIV_STAGES];
    logic signed [31:0] a_reg;
    logic [31:0] f_abs;

    assign f_abs = f[31] ? (~f + 32'd1) : f;

    always_ff @(posedge clk)
    begin
        num_reg[0]  <= {f_abs, 8'd0};
        rem_reg[0]  <= 16'd0;
        m_reg[0]    <= m;
        neg_reg[0]  <= f[31];
        zero_reg[0] <= (f == 32'sd0);
    end

    for (genvar g = 0; g < pise_pkg::DIV_STAGES; g++) begin : g_stage
        logic [39:0] num_next;
        logic [15:0] rem_next;

        always_comb
        begin
            logic [39:0] n;
            logic [16:0] t;
            logic [15:0] rr;
            n  = num_reg[g];
            rr = rem_reg[g];
            for (int i = 0; i < pise_pkg::DIV_BITS_PER_STAGE; i++)
            begin
                t = {rr, n[39]};
                n = {n[38:0], 1'b0};
                if (t >= {1'b0, m_reg[g]})
                begin
                    t    = t - {1'b0, m_reg[g]};
                    n[0] = 1'b1;
                end
                rr = t[15:0];
            end
            num_next = n;
            rem_next = rr;
        end

        always_ff @(posedge clk)
        begin
            num_reg[g+1]  <= num_next;
            rem_reg[g+1]  <= rem_next;
            m_reg[g+1]    <= m_reg[g];
            neg_reg[g+1]  <= neg_reg[g];
            zero_reg[g+1] <= zero_reg[g];
        end
    end

    // zero divisor yields an all-ones quotient, which saturates by sign
    logic [39:0] q;
    logic signed [31:0] a_next;
    assign q = num_reg[pise_pkg::DIV_STAGES];

    always_comb
    begin
        if (zero_reg[pise_pkg::DIV_STAGES])
            a_next = 32'sd0;
        else if (neg_reg[pise_pkg::DIV_STAGES])
            a_next = (q > 40'h00_8000_0000) ? pise_pkg::S32_MIN : (~q[31:0] + 32'd1);
        else
            a_next = (q >= 40'h00_8000_0000) ? pise_pkg::S32_MAX : q[31:0];
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
    end

    assign a = a_reg;

endmodule
`default_nettype wire

FILE: rtl/pise_axis.sv
// One axis of the integrator: divider, then dt multiplies, rounding and saturation.
// Depends on pise_pkg and pise_div.
`timescale 1ns / 1ps
`default_nettype none
module pise_axis (
    input  wire logic               clk,
    input  wire logic signed [31:0] r,
    input  wire logic signed [31:0] v,
    input  wire logic signed [31:0] f,
    input  wire logic        [15:0] m,
    input  wire logic        [23:0] dt,
    input  wire logic               second_order,
    output logic signed [31:0]      new_pos,
    output logic signed [31:0]      new_vel
);

    logic signed [31:0] a;
    logic signed [31:0] r_dly_reg [0:pise_pkg::DIV_LAT-1];
    logic signed [31:0] v_dly_reg [0:pise_pkg::DIV_LAT-1];
    logic signed [24:0] dt_s;

    pise_div u_div (
        .clk (clk),
        .f   (f),
        .m   (m),
        .a   (a)
    );

    assign dt_s = $signed({1'b0, dt});

    always_ff @(posedge clk)
    begin
        r_dly_reg[0] <= r;
        v_dly_reg[0] <= v;
        for (int i = 1; i < pise_pkg::DIV_LAT; i++)
        begin
            r_dly_reg[i] <= r_dly_reg[i-1];
            v_dly_reg[i] <= v_dly_reg[i-1];
        end
    end

    // stage 1: products with dt
    logic signed [56:0] pa_reg, pv_reg;
    logic signed [31:0] r1_reg, v1_reg;
    // stage 2: rounded increments
    logic signed [32:0] dv2_reg, dr2_reg;
    logic signed [31:0] r2_reg, v2_reg;
    // stage 3: second-order product and saturated new velocity
    logic signed [57:0] ph3_reg;
    logic signed [32:0] dr3_reg;
    logic signed [31:0] r3_reg, nv3_reg;
    // stage 4: outputs
    logic signed [31:0] np_reg, nv_reg;

    logic signed [56:0] pa_rnd, pv_rnd;
    logic signed [57:0] ph_rnd;
    logic signed [32:0] hr;
    logic signed [34:0] np_sum;
    logic signed [34:0] nv_sum;

    assign pa_rnd = pa_reg + 57'sd8388608;
    assign pv_rnd = pv_reg + 57'sd8388608;
    assign ph_rnd = ph3_reg + 58'sd16777216;
    assign hr     = second_order ? ph_rnd[57:25] : 33'sd0;
    assign nv_sum = 35'(v2_reg) + 35'(dv2_reg);
    assign np_sum = 35'(r3_reg) + 35'(dr3_reg) + 35'(hr);

    always_ff @(posedge clk)
    begin
        pa_reg  <= a * dt_s;
        pv_reg  <= v_dly_reg[pise_pkg::DIV_LAT-1] * dt_s;
        r1_reg  <= r_dly_reg[pise_pkg::DIV_LAT-1];
        v1_reg  <= v_dly_reg[pise_pkg::DIV_LAT-1];

        dv2_reg <= pa_rnd[56:24];
        dr2_reg <= pv_rnd[56:24];
        r2_reg  <= r1_reg;
        v2_reg  <= v1_reg;

        ph3_reg <= dv2_reg * dt_s;
        dr3_reg <= dr2_reg;
        r3_reg  <= r2_reg;
        nv3_reg <= pise_pkg::sat35(nv_sum);

        np_reg  <= pise_pkg::sat35(np_sum);
        nv_reg  <= nv3_reg;
    end

    assign new_pos = np_reg;
    assign new_vel = nv_reg;

endmodule
`default_nettype wire

FILE: rtl/particle_integrator_step_core.sv
// Top level of the particle integrator step core: config registers, valid pipe, 3 axes.
// Depends on pise_pkg and pise_axis.
`timescale 1ns / 1ps
`default_nettype none
// One particle per clock: busy is never raised, so start may be held high every
// cycle. Each word leaves on done after the pipelined restoring divider that forms
// force/mass and then the dt multiplies, rounding and the saturating sums.
// Results appear for one cycle only; the
// receiver must take them as they come. Write mode/time_step only while idle.
module particle_integrator_step_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               wr_en,
    input  wire logic               wr_index,
    input  wire logic        [23:0] wr_data,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [31:0] vel_x,
    input  wire logic signed [31:0] vel_y,
    input  wire logic signed [31:0] vel_z,
    input  wire logic signed [31:0] force_x,
    input  wire logic signed [31:0] force_y,
    input  wire logic signed [31:0] force_z,
    input  wire logic        [15:0] mass,
    output logic                    done,
    output logic signed [31:0]      new_pos_x,
    output logic signed [31:0]      new_pos_y,
    output logic signed [31:0]      new_pos_z,
    output logic signed [31:0]      new_vel_x,
    output logic signed [31:0]      new_vel_y,
    output logic signed [31:0]      new_vel_z
);

    pise_pkg::mode_t mode_reg;
    logic [23:0]     time_step_reg;
    logic [pise_pkg::TOTAL_LAT-1:0] vld_reg;
    logic            second_order;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= pise_pkg::MODE_EULER;
            time_step_reg <= pise_pkg::TIME_STEP_RESET;
        end
        else if (wr_en)
        begin
            case (pise_pkg::reg_index_t'(wr_index))
                pise_pkg::REG_MODE:      mode_reg <= pise_pkg::mode_t'(wr_data[1:0]);
                pise_pkg::REG_TIME_STEP: time_step_reg <= wr_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[pise_pkg::TOTAL_LAT-2:0], start & ~busy};
    end

    assign done = vld_reg[pise_pkg::TOTAL_LAT-1];
    assign second_order = (mode_reg == pise_pkg::MODE_MIDPOINT) ||
                          (mode_reg == pise_pkg::MODE_RK4);

    pise_axis u_axis_x (
        .clk(clk), .r(pos_x), .v(vel_x), .f(force_x), .m(mass),
        .dt(time_step_reg), .second_order(second_order),
        .new_pos(new_pos_x), .new_vel(new_vel_x)
    );

    pise_axis u_axis_y (
        .clk(clk), .r(pos_y), .v(vel_y), .f(force_y), .m(mass),
        .dt(time_step_reg), .second_order(second_order),
        .new_pos(new_pos_y), .new_vel(new_vel_y)
    );

    pise_axis u_axis_z (
        .clk(clk), .r(pos_z), .v(vel_z), .f(force_z), .m(mass),
        .dt(time_step_reg), .second_order(second_order),
        .new_pos(new_pos_z), .new_vel(new_vel_z)
    );

endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for particle_integrator_step_core: directed and random particles
// over several mode/time-step settings, checked against an in-bench integrator model.
// Depends on pise_pkg and the core RTL.
`timescale 1ns / 1ps
module tb;

    typedef struct {
        logic signed [31:0] pos[3];
        logic signed [31:0] vel[3];
        logic signed [31:0] frc[3];
        logic        [15:0] mass;
    } particle_t;

    typedef struct {
        logic signed [31:0] pos[3];
        logic signed [31:0] vel[3];
    } step_res_t;

    class step_scoreboard;
        step_res_t pending[$];
        int        errors = 0;
        string     pos_name[3] = '{"new_pos_x", "new_pos_y", "new_pos_z"};
        string     vel_name[3] = '{"new_vel_x", "new_vel_y", "new_vel_z"};

        function void note(step_res_t r);
            pending.push_back(r);
        endfunction

        function void check(step_res_t got);
            step_res_t want;
            if (pending.size() == 0)
            begin
                $error("result word with no particle outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int k = 0; k < 3; k++)
            begin
                if (got.pos[k] !== want.pos[k])
                begin
                    $error("%s: expected %h, got %h", pos_name[k], want.pos[k], got.pos[k]);
                    errors++;
                end
                if (got.vel[k] !== want.vel[k])
                begin
                    $error("%s: expected %h, got %h", vel_name[k], want.vel[k], got.vel[k]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0, start = 0, wr_en = 0, wr_index = 0;
    logic [23:0] wr_data = '0;
    logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0, vel_x = 0, vel_y = 0, vel_z = 0;
    logic signed [31:0] force_x = 0, force_y = 0, force_z = 0;
    logic [15:0] mass = 16'd256;
    logic busy, done;
    logic signed [31:0] new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;

    pise_pkg::mode_t cur_mode = pise_pkg::MODE_EULER;
    logic [23:0]     cur_dt   = pise_pkg::TIME_STEP_RESET;
    step_scoreboard sb = new();
    int idle_cycles = 0;

    particle_integrator_step_core u_top (.*);

    initial forever #4 clk = ~clk;

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // round to nearest, ties up
    function automatic longint rnd_shift(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic step_res_t integrate(particle_t p);
        step_res_t r;
        longint f, a, v, dv, np, dt;
        dt = longint'(cur_dt);
        for (int k = 0; k < 3; k++)
        begin
            f = p.frc[k];
            v = p.vel[k];
            if (p.mass == 0)
                a = (f > 0) ? 64'sd2147483647 : (f < 0) ? -64'sd2147483648 : 0;
            else
                a = sat32((f * 256) / longint'(p.mass));
            dv = rnd_shift(a * dt, 24);
            np = longint'(p.pos[k]) + rnd_shift(v * dt, 24);
            if (cur_mode == pise_pkg::MODE_MIDPOINT || cur_mode == pise_pkg::MODE_RK4)
                np += rnd_shift(dv * dt, 25);
            r.pos[k] = 32'(sat32(np));
            r.vel[k] = 32'(sat32(v + dv));
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        particle_t p;
        step_res_t got;
        if (rst_n && start && !busy)
        begin
            p.pos = '{pos_x, pos_y, pos_z};
            p.vel = '{vel_x, vel_y, vel_z};
            p.frc = '{force_x, force_y, force_z};
            p.mass = mass;
            sb.note(integrate(p));
        end
        if (rst_n && done)
        begin
            got.pos = '{new_pos_x, new_pos_y, new_pos_z};
            got.vel = '{new_vel_x, new_vel_y, new_vel_z};
            sb.check(got);
        end
        idle_cycles = ((start && !busy) || done) ? 0 : idle_cycles + 1;
    end

    initial
    begin
        @(posedge rst_n);
        wait (idle_cycles >= 4000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic write_reg(pise_pkg::reg_index_t idx, logic [23:0] data);
        wr_en = 1; wr_index = idx; wr_data = data;
        @(negedge clk);
        wr_en = 0;
        if (idx == pise_pkg::REG_MODE) cur_mode = pise_pkg::mode_t'(data[1:0]);
        else cur_dt = data;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send(particle_t p);
        {pos_x, pos_y, pos_z} = {p.pos[0], p.pos[1], p.pos[2]};
        {vel_x, vel_y, vel_z} = {p.vel[0], p.vel[1], p.vel[2]};
        {force_x, force_y, force_z} = {p.frc[0], p.frc[1], p.frc[2]};
        mass = p.mass;
        start = 1;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start = 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (pise_pkg::TOTAL_LAT + 4) @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1, 2: return $signed($urandom) >>> $urandom_range(4, 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        for (int k = 0; k < 3; k++)
        begin
            p.pos[k] = rand_q();
            p.vel[k] = rand_q();
            p.frc[k] = rand_q();
        end
        case ($urandom_range(0, 9))
            0: p.mass = 16'($urandom_range(0, 15));
            1: p.mass = 16'hFFFF;
            default: p.mass = 16'($urandom_range(1, 65535));
        endcase
        return p;
    endfunction

    task automatic random_phase(int n);
        int sent = 0;
        int burst;
        while (sent < n)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < n; i++)
            begin
                send(rand_particle());
                sent++;
            end
            start = 0;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        drain();
    endtask

    task automatic directed();
        particle_t p;
        logic signed [31:0] ext[4] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1};
        for (int i = 0; i < 4; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p.pos[k] = ext[(i + k) % 4];
                p.vel[k] = ext[(i + k + 1) % 4];
                p.frc[k] = ext[(i + k + 2) % 4];
            end
            p.mass = (i == 0) ? 16'd1 : (i == 1) ? 16'hFFFF : (i == 2) ? 16'd0 : 16'd256;
            send(p);
        end
        // zero mass with mixed force signs
        p.frc = '{32'sd5, -32'sd5, 32'sd0};
        p.mass = 0;
        send(p);
        // ordinary particle, unit mass
        p.pos = '{32'sh0100_0000, -32'sh0080_0000, 32'sd12345};
        p.vel = '{32'sh0200_0000, 32'sh0000_8000, -32'sh0300_0000};
        p.frc = '{32'sh0098_0000, -32'sh0010_0000, 32'sd77};
        p.mass = 16'h0100;
        send(p);
        drain();
    endtask

    initial
    begin
        logic [23:0] dts[6];
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        directed();
        dts = '{24'd0, 24'hFFFFFF, pise_pkg::TIME_STEP_RESET, 24'd1, 24'h800000, 24'h000000};
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(pise_pkg::REG_MODE, {22'($urandom_range(0, 4194303)), 2'(ph % 4)});
            write_reg(pise_pkg::REG_TIME_STEP,
                      (ph < 6 && ph != 5) ? dts[ph] : 24'($urandom));
            directed();
            random_phase(120);
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
